FILE: src/tcm_pkg.sv
`default_nettype none

package tcm_pkg;

    localparam int WINDOW_BITS = 32;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd500000;

    // result kinds, carried on the master tuser
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    localparam logic CH_FIRST  = 1'b0;
    localparam logic CH_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_READ,
        ST_COMPARE
    } back_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

`default_nettype wire

FILE: src/tcm_hit_fifo.sv
`default_nettype none

module tcm_hit_fifo #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 112
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  tcm_pkg::fifo_ctl_t    ctl,
    input  wire  [WIDTH-1:0]      wr_data,
    output logic [WIDTH-1:0]      rd_data,
    output tcm_pkg::fifo_stat_t   stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctl.push)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        unique case ({ctl.push, ctl.pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // head is read each cycle; a pop updates head_reg, then rd_data_reg
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        rd_data_reg <= mem[head_reg];
    end

    assign rd_data    = rd_data_reg;
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FW'(DEPTH));

endmodule

`default_nettype wire

FILE: src/tcm_front.sv
`default_nettype none

module tcm_front #(
    parameter int HIT_W = 112,
    parameter int IN_W  = 112
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [IN_W-1:0]   s_tdata,
    input  wire               s_tuser,
    output logic              hit_valid,
    input  wire               hit_ready,
    output logic              hit_channel,
    output logic [HIT_W-1:0]  hit_data
);

    // two-entry queue between the slave port and the back end
    logic [HIT_W-1:0] q_data_reg [2];
    logic             q_ch_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign hit_valid = (count_reg != 2'd0);
    assign pop      = hit_valid && hit_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= s_tdata[HIT_W-1:0];
            q_ch_reg[wr_ptr_reg]   <= s_tuser;
        end
    end

    assign hit_channel = q_ch_reg[rd_ptr_reg];
    assign hit_data    = q_data_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: src/tcm_back.sv
`default_nettype none

module tcm_back #(
    parameter int FIFO_DEPTH = 256,
    parameter int STAMP_BITS = 48,
    parameter int VALUE_BITS = 32,
    parameter int OUT_W      = 152
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire  [tcm_pkg::WINDOW_BITS-1:0]    window,
    input  wire                                hit_valid,
    output logic                               hit_ready,
    input  wire                                hit_channel,
    input  wire  [STAMP_BITS+2*VALUE_BITS-1:0] hit_data,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [OUT_W-1:0]                   m_tdata,
    output logic                               m_tuser
);

    import tcm_pkg::*;

    localparam int HIT_W = STAMP_BITS + 2 * VALUE_BITS;
    localparam int CMP_W = (STAMP_BITS > WINDOW_BITS) ? STAMP_BITS : WINDOW_BITS;

    back_state_t state_reg, state_next;

    fifo_ctl_t  ctl_a, ctl_b;
    fifo_stat_t stat_a, stat_b;
    logic [HIT_W-1:0] rd_a, rd_b;

    logic [STAMP_BITS-1:0] sa, sb, diff;
    logic [VALUE_BITS-1:0] ta, tb, ea, eb;
    logic                  a_lt_b, in_window;
    logic                  fire, tgt_full, out_free;
    logic                  load_match, load_drop;

    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg;
    logic                  dch_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [VALUE_BITS-1:0] tag_reg, e1_reg, e2_reg;
    logic                  mismatch_reg;

    tcm_hit_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(HIT_W)) u_fifo_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_a),
        .wr_data (hit_data),
        .rd_data (rd_a),
        .stat    (stat_a)
    );

    tcm_hit_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(HIT_W)) u_fifo_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_b),
        .wr_data (hit_data),
        .rd_data (rd_b),
        .stat    (stat_b)
    );

    assign sa = rd_a[STAMP_BITS-1:0];
    assign ta = rd_a[STAMP_BITS+VALUE_BITS-1:STAMP_BITS];
    assign ea = rd_a[HIT_W-1:STAMP_BITS+VALUE_BITS];
    assign sb = rd_b[STAMP_BITS-1:0];
    assign tb = rd_b[STAMP_BITS+VALUE_BITS-1:STAMP_BITS];
    assign eb = rd_b[HIT_W-1:STAMP_BITS+VALUE_BITS];

    assign a_lt_b    = (sa < sb);
    assign diff      = a_lt_b ? (sb - sa) : (sa - sb);
    assign in_window = (CMP_W'(diff) <= CMP_W'(window));

    assign tgt_full = (hit_channel == CH_FIRST) ? stat_a.full : stat_b.full;
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = hit_valid && hit_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_TAKE:
            begin
                if (fire && !tgt_full)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = (!stat_a.empty && !stat_b.empty) ? ST_COMPARE : ST_TAKE;
            end
            ST_COMPARE:
            begin
                if (!in_window)
                begin
                    state_next = ST_READ;
                end
                else if (out_free)
                begin
                    state_next = ST_TAKE;
                end
            end
            default: state_next = ST_TAKE;
        endcase
    end

    always_comb
    begin
        hit_ready  = 1'b0;
        ctl_a      = '0;
        ctl_b      = '0;
        load_match = 1'b0;
        load_drop  = 1'b0;
        unique case (state_reg)
            ST_TAKE:
            begin
                // an overflow needs the output register, a push does not
                hit_ready = !tgt_full || out_free;
                if (hit_valid && hit_ready)
                begin
                    if (tgt_full)
                    begin
                        load_drop = 1'b1;
                    end
                    else if (hit_channel == CH_FIRST)
                    begin
                        ctl_a.push = 1'b1;
                    end
                    else
                    begin
                        ctl_b.push = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                hit_ready = 1'b0;
            end
            ST_COMPARE:
            begin
                if (in_window)
                begin
                    if (out_free)
                    begin
                        load_match = 1'b1;
                        ctl_a.pop  = 1'b1;
                        ctl_b.pop  = 1'b1;
                    end
                end
                else if (a_lt_b)
                begin
                    ctl_a.pop = 1'b1;
                end
                else
                begin
                    ctl_b.pop = 1'b1;
                end
            end
            default: hit_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        if (load_match || load_drop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TAKE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_match)
        begin
            kind_reg     <= KIND_MATCH;
            dch_reg      <= CH_FIRST;
            stamp_reg    <= sa;
            tag_reg      <= ta;
            e1_reg       <= ea;
            e2_reg       <= eb;
            mismatch_reg <= (ta != tb);
        end
        else if (load_drop)
        begin
            kind_reg     <= KIND_DROP;
            dch_reg      <= hit_channel;
            stamp_reg    <= '0;
            tag_reg      <= '0;
            e1_reg       <= '0;
            e2_reg       <= '0;
            mismatch_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = OUT_W'({mismatch_reg, e2_reg, e1_reg, tag_reg, stamp_reg, dch_reg});

endmodule

`default_nettype wire

FILE: src/timestamp_coincidence_matcher.sv
// flow: an accepted hit waits in the two-entry front queue, is pushed into its channel store
//   in the take step, then both heads are read and compared; a compare outside the window
//   drops the earlier head and reads again, and a coincidence is registered on the master side
// a hit for a full store is registered on the master side as an overflow, with no compare;
//   the back end takes no new hit until its read and compare steps end, the front queue holds two
// reset: control, fill counts and queue cleared, window set to 500000; hit storage is not cleared
`default_nettype none

module timestamp_coincidence_matcher #(
    parameter int FIFO_DEPTH = 256,
    parameter int STAMP_BITS = 48,
    parameter int VALUE_BITS = 32
) (
    input  wire                                              clk,
    input  wire                                              rst_n,
    input  wire                                              cfg_we,
    input  wire  [tcm_pkg::WINDOW_BITS-1:0]                  cfg_wdata,
    input  wire                                              s_tvalid,
    output logic                                             s_tready,
    // stamp, tag, energy
    input  wire  [((STAMP_BITS+2*VALUE_BITS+7)/8)*8-1:0]     s_tdata,
    // channel
    input  wire                                              s_tuser,
    output logic                                             m_tvalid,
    input  wire                                              m_tready,
    // dropped_channel, first_stamp, first_tag, first_energy, second_energy, tag_mismatch
    output logic [((2+STAMP_BITS+3*VALUE_BITS+7)/8)*8-1:0]   m_tdata,
    // kind
    output logic                                             m_tuser
);

    import tcm_pkg::*;

    localparam int HIT_W = STAMP_BITS + 2 * VALUE_BITS;
    localparam int IN_W  = ((HIT_W + 7) / 8) * 8;
    localparam int OUT_W = ((2 + STAMP_BITS + 3 * VALUE_BITS + 7) / 8) * 8;

    logic [WINDOW_BITS-1:0] window_reg, window_next;

    logic             hit_valid, hit_ready, hit_channel;
    logic [HIT_W-1:0] hit_data;

    assign window_next = cfg_we ? cfg_wdata : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    tcm_front #(.HIT_W(HIT_W), .IN_W(IN_W)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .hit_valid   (hit_valid),
        .hit_ready   (hit_ready),
        .hit_channel (hit_channel),
        .hit_data    (hit_data)
    );

    tcm_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .STAMP_BITS (STAMP_BITS),
        .VALUE_BITS (VALUE_BITS),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .window      (window_reg),
        .hit_valid   (hit_valid),
        .hit_ready   (hit_ready),
        .hit_channel (hit_channel),
        .hit_data    (hit_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

FILE: test/timestamp_coincidence_matcher_tb.sv
`default_nettype none

module timestamp_coincidence_matcher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tcm_pkg::*;

    localparam int FIFO_DEPTH  = 256;
    localparam int IDLE_CYCLES = 4 * FIFO_DEPTH + 64;
    localparam int LIMIT       = 1000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic        kind;
        logic        dropped_channel;
        logic [47:0] first_stamp;
        logic [31:0] first_tag;
        logic [31:0] first_energy;
        logic [31:0] second_energy;
        logic        tag_mismatch;
    } coinc_t;

    typedef enum {ROW_HIT, ROW_WINDOW} row_op_t;
    typedef enum {EXP_MODEL, EXP_NONE, EXP_WORD} exp_mode_t;

    typedef struct {
        row_op_t     op;
        logic        ch;
        logic [47:0] stamp;
        logic [31:0] tag;
        logic [31:0] energy;
        exp_mode_t   mode;
        coinc_t      want;
    } row_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [151:0] m_tdata;
    logic         m_tuser;

    // predictor state: one hit queue per channel
    logic [47:0] q_stamp  [2][FIFO_DEPTH];
    logic [31:0] q_tag    [2][FIFO_DEPTH];
    logic [31:0] q_energy [2][FIFO_DEPTH];
    int          q_head [2];
    int          q_tail [2];
    int          q_fill [2];
    logic [31:0] win_now = WINDOW_RESET;

    coinc_t      due_matches[$];
    row_t        stim_rows[$];
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          hits_sent     = 0;
    int          tx_mode_left  = 0;
    bit          tx_bursty     = 1'b0;
    int          rx_mode_left  = 0;
    bit          rx_bursty     = 1'b0;
    int          rx_stall_left = 0;
    int          hold_left     = 0;
    int          pressure_req  = 0;
    int          pressure_seen = 0;
    logic        rx_ready;
    coinc_t      got_word;

    timestamp_coincidence_matcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic void expect_word(input coinc_t w);
        due_matches.insert(due_matches.size(), w);
    endfunction

    function automatic void add_row(input row_t row);
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [47:0] rand_upto(input logic [47:0] lim);
        if (lim <= 48'hFFFF_FFFF)
            return 48'($urandom_range(0, lim[31:0]));
        return rand48() % (lim + 48'd1);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void pop_head(input logic ch);
        q_head[ch] = (q_head[ch] + 1) % FIFO_DEPTH;
        q_fill[ch]--;
    endfunction

    // drop if full, or queue and compare heads until a match or a side runs dry
    function automatic bit queue_hit(input logic ch, input logic [47:0] st,
                                     input logic [31:0] tg, input logic [31:0] en,
                                     output coinc_t res);
        logic [47:0] sa;
        logic [47:0] sb;
        logic [47:0] diff;
        res = '0;
        if (q_fill[ch] >= FIFO_DEPTH)
        begin
            res.kind            = KIND_DROP;
            res.dropped_channel = ch;
            return 1'b1;
        end
        q_stamp[ch][q_tail[ch]]  = st;
        q_tag[ch][q_tail[ch]]    = tg;
        q_energy[ch][q_tail[ch]] = en;
        q_tail[ch] = (q_tail[ch] + 1) % FIFO_DEPTH;
        q_fill[ch]++;
        while (q_fill[CH_FIRST] > 0 && q_fill[CH_SECOND] > 0)
        begin
            sa   = q_stamp[CH_FIRST][q_head[CH_FIRST]];
            sb   = q_stamp[CH_SECOND][q_head[CH_SECOND]];
            diff = (sa >= sb) ? sa - sb : sb - sa;
            if (diff <= {16'd0, win_now})
            begin
                res.kind          = KIND_MATCH;
                res.first_stamp   = sa;
                res.first_tag     = q_tag[CH_FIRST][q_head[CH_FIRST]];
                res.first_energy  = q_energy[CH_FIRST][q_head[CH_FIRST]];
                res.second_energy = q_energy[CH_SECOND][q_head[CH_SECOND]];
                res.tag_mismatch  = (q_tag[CH_FIRST][q_head[CH_FIRST]]
                                     != q_tag[CH_SECOND][q_head[CH_SECOND]]);
                pop_head(CH_FIRST);
                pop_head(CH_SECOND);
                return 1'b1;
            end
            if (sa < sb)
                pop_head(CH_FIRST);
            else
                pop_head(CH_SECOND);
        end
        return 1'b0;
    endfunction

    // drive one word and wait for it to be taken; predicts at the accepting edge
    task automatic send_hit(input logic ch, input logic [47:0] st, input logic [31:0] tg,
                            input logic [31:0] en, output bit got, output coinc_t res);
        int gap;
        if (tx_mode_left == 0)
        begin
            tx_bursty    = ($urandom_range(0, 2) != 0);
            tx_mode_left = $urandom_range(20, 200);
        end
        tx_mode_left--;
        gap = (tx_bursty && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= {en, tg, st};
        do
            @(posedge clk);
        while (!s_tready);
        hits_sent++;
        got = queue_hit(ch, st, tg, en, res);
    endtask

    task automatic offer(input logic ch, input logic [47:0] st, input logic [31:0] tg,
                         input logic [31:0] en);
        bit     got;
        coinc_t res;
        send_hit(ch, st, tg, en, got, res);
        if (got)
            expect_word(res);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_matches.size() != 0)
            @(posedge clk);
        // a hit that gives no result may still be dropping heads
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [31:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        win_now = v;
    endtask

    // empty the other queue, then push this channel past full
    task automatic flood_channel(input logic ch);
        int n;
        while (q_fill[!ch] != 0)
            offer(ch, 48'hFFFF_FFFF_FFFF, $urandom, $urandom);
        n = FIFO_DEPTH - q_fill[ch] + 3;
        repeat (n) offer(ch, rand48(), $urandom, $urandom);
    endtask

    task automatic run_traffic(input int n);
        int          stop;
        int          r;
        int          k;
        logic [47:0] t;
        logic [47:0] jit;
        logic [47:0] st_pair [2];
        logic [31:0] tg;
        logic [31:0] tg2;
        logic        c;
        logic        hi;
        stop = hits_sent + n;
        t    = rand48();
        while (hits_sent < stop)
        begin
            r = $urandom_range(0, 99);
            c = 1'($urandom_range(0, 1));
            if (r < 60)
            begin
                jit = rand_upto({16'd0, win_now});
                if ($urandom_range(0, 4) == 0)
                    jit = {16'd0, win_now} + 48'($urandom_range(1, 4));
                hi = 1'($urandom_range(0, 1));
                st_pair[hi]  = t + jit;
                st_pair[!hi] = t;
                tg  = $urandom;
                tg2 = ($urandom_range(0, 99) < 85) ? tg : $urandom;
                offer(c, st_pair[c], tg, $urandom);
                offer(!c, st_pair[!c], tg2, $urandom);
            end
            else if (r < 85)
                offer(c, t, $urandom, $urandom);
            else if (r < 95)
            begin
                k = $urandom_range(2, 4);
                repeat (k)
                begin
                    offer(c, t, $urandom, $urandom);
                    t = t + rand_upto({16'd0, win_now} + 48'd4);
                end
            end
            else
                offer(c, rand48(), $urandom, $urandom);
            t = t + rand_upto({15'd0, win_now, 1'b0} + 48'd16);
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (pressure_req != pressure_seen)
        begin
            pressure_seen = pressure_req;
            hold_left     = HOLD_CYCLES;
        end
        if (rx_mode_left == 0)
        begin
            rx_bursty    = ($urandom_range(0, 2) != 0);
            rx_mode_left = $urandom_range(50, 400);
        end
        rx_mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            rx_ready = 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            rx_ready = 1'b0;
        end
        else
        begin
            rx_ready = 1'b1;
            if (rx_bursty && $urandom_range(0, 99) < 25)
                rx_stall_left = pick_gap();
        end
        m_tready <= rx_ready;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.kind            = m_tuser;
            got_word.dropped_channel = m_tdata[0];
            got_word.first_stamp     = m_tdata[48:1];
            got_word.first_tag       = m_tdata[80:49];
            got_word.first_energy    = m_tdata[112:81];
            got_word.second_energy   = m_tdata[144:113];
            got_word.tag_mismatch    = m_tdata[145];
            if (due_matches.size() == 0)
                report("result word with nothing expected");
            else
            begin
                check_field("kind", 64'(got_word.kind), 64'(due_matches[0].kind));
                check_field("dropped_channel", 64'(got_word.dropped_channel),
                            64'(due_matches[0].dropped_channel));
                check_field("first_stamp", 64'(got_word.first_stamp),
                            64'(due_matches[0].first_stamp));
                check_field("first_tag", 64'(got_word.first_tag),
                            64'(due_matches[0].first_tag));
                check_field("first_energy", 64'(got_word.first_energy),
                            64'(due_matches[0].first_energy));
                check_field("second_energy", 64'(got_word.second_energy),
                            64'(due_matches[0].second_energy));
                check_field("tag_mismatch", 64'(got_word.tag_mismatch),
                            64'(due_matches[0].tag_mismatch));
                void'(due_matches.pop_front());
            end
        end
    end

    function automatic row_t hit_row(input logic ch, input logic [47:0] st,
                                     input logic [31:0] tg, input logic [31:0] en,
                                     input exp_mode_t mode, input coinc_t want = '0);
        row_t row;
        row.op     = ROW_HIT;
        row.ch     = ch;
        row.stamp  = st;
        row.tag    = tg;
        row.energy = en;
        row.mode   = mode;
        row.want   = want;
        return row;
    endfunction

    function automatic row_t win_row(input logic [31:0] v);
        row_t row;
        row     = hit_row(CH_FIRST, '0, v, '0, EXP_NONE);
        row.op  = ROW_WINDOW;
        return row;
    endfunction

    function automatic coinc_t coin(input logic [47:0] st, input logic [31:0] tg,
                                    input logic [31:0] ea, input logic [31:0] eb,
                                    input logic mis);
        coinc_t c;
        c               = '0;
        c.kind          = KIND_MATCH;
        c.first_stamp   = st;
        c.first_tag     = tg;
        c.first_energy  = ea;
        c.second_energy = eb;
        c.tag_mismatch  = mis;
        return c;
    endfunction

    initial
    begin
        bit     got;
        coinc_t res;

        for (int c = 0; c < 2; c++)
        begin
            q_head[c] = 0;
            q_tail[c] = 0;
            q_fill[c] = 0;
        end

        // window at its reset value
        add_row(hit_row(CH_FIRST, 48'd0, 32'd0, 32'd0, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'd0, 32'd0, 32'hFFFF_FFFF, EXP_WORD,
                        coin(48'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0)));
        add_row(hit_row(CH_FIRST, 48'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        EXP_NONE));
        // difference exactly the window
        add_row(hit_row(CH_SECOND, 48'd501000, 32'd0, 32'd5, EXP_WORD,
                        coin(48'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 1'b1)));
        // one past the window: earlier head dropped
        add_row(hit_row(CH_FIRST, 48'd2000000, 32'd1, 32'd1, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'd2500001, 32'd1, 32'd2, EXP_NONE));
        add_row(hit_row(CH_FIRST, 48'd2500001, 32'd7, 32'd3, EXP_WORD,
                        coin(48'd2500001, 32'd7, 32'd3, 32'd2, 1'b1)));
        // stamps going backwards within a channel
        add_row(hit_row(CH_FIRST, 48'd9000000, 32'd2, 32'd4, EXP_NONE));
        add_row(hit_row(CH_FIRST, 48'd100, 32'd3, 32'd5, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'd300, 32'd3, 32'd6, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'd9000100, 32'd2, 32'd7, EXP_MODEL));
        add_row(hit_row(CH_SECOND, 48'd600, 32'd9, 32'd8, EXP_MODEL));
        // two queued on one side, matched one per push
        add_row(hit_row(CH_FIRST, 48'd20000000, 32'hA, 32'h11, EXP_NONE));
        add_row(hit_row(CH_FIRST, 48'd20000010, 32'hB, 32'h12, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'd20000005, 32'hA, 32'h13, EXP_MODEL));
        add_row(hit_row(CH_SECOND, 48'd20000012, 32'hC, 32'h14, EXP_MODEL));
        // zero window: equal stamps only
        add_row(win_row(32'd0));
        add_row(hit_row(CH_FIRST, 48'hFFFF_FFFF_FFFF, 32'h5A5A_A5A5,
                        32'h1234_5678, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'hFFFF_FFFF_FFFF, 32'h5A5A_A5A5,
                        32'hEDCB_A987, EXP_WORD,
                        coin(48'hFFFF_FFFF_FFFF, 32'h5A5A_A5A5,
                             32'h1234_5678, 32'hEDCB_A987, 1'b0)));
        add_row(hit_row(CH_FIRST, 48'd5, 32'd0, 32'd0, EXP_NONE));
        add_row(hit_row(CH_SECOND, 48'd6, 32'd0, 32'h21, EXP_NONE));
        // widest window
        add_row(win_row(32'hFFFF_FFFF));
        add_row(hit_row(CH_FIRST, 48'h1_0000_0005, 32'h8000_0001, 32'h7FFF_FFFF,
                        EXP_WORD,
                        coin(48'h1_0000_0005, 32'h8000_0001, 32'h7FFF_FFFF,
                             32'h21, 1'b1)));
        add_row(hit_row(CH_SECOND, 48'd0, 32'd0, 32'd0, EXP_NONE));
        add_row(hit_row(CH_FIRST, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, EXP_NONE));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].op == ROW_WINDOW)
                set_window(stim_rows[i].tag);
            else
            begin
                send_hit(stim_rows[i].ch, stim_rows[i].stamp, stim_rows[i].tag,
                         stim_rows[i].energy, got, res);
                if (stim_rows[i].mode == EXP_WORD)
                    expect_word(stim_rows[i].want);
                else if (stim_rows[i].mode == EXP_MODEL && got)
                    expect_word(res);
            end
        end

        // full queues on both channels
        set_window(32'd1000);
        flood_channel(CH_FIRST);
        flood_channel(CH_SECOND);

        set_window(WINDOW_RESET);
        pressure_req++;
        run_traffic(200);
        set_window(32'd0);
        run_traffic(200);
        set_window(32'hFFFF_FFFF);
        run_traffic(200);
        set_window($urandom);
        run_traffic(200);
        set_window($urandom_range(1, 64));
        run_traffic(200);

        wait_idle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
